### rtl/rk4_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rk4_pkg
// Shared types and constants for the friction spring RK4 integrator.
// ----------------------------------------------------------------------------
package rk4_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT,
		ST_OUT
	} rk4_state_t;

	typedef enum logic [2:0] {
		REG_K   = 3'd0,
		REG_C   = 3'd1,
		REG_INVM = 3'd2,
		REG_MU  = 3'd3,
		REG_H   = 3'd4
	} rk4_reg_t;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// datapath microcode address space and counter width
	localparam int NSTEP = 64;
	localparam int STEP_W = 6;

	typedef struct packed {
		logic start_load;
		logic start_step;
	} rk4_cmd_t;

	typedef struct packed {
		logic done;
	} rk4_sts_t;

endpackage
`default_nettype wire

### rtl/rk4_friction_spring_integrator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rk4_friction_spring_integrator_top
// RK4 integrator for a hardening spring with dry friction, Q16.16.
// ----------------------------------------------------------------------------
// channel | signals                                    | word
// in      | in_valid/in_ready                          | opcode, load_*
// out     | out_valid/out_ready                        | position/velocity/flag
// cfg     | cfg_we, cfg_index, cfg_data                | register write
// A load passes through accept, done and hand over.
// A step passes through accept, 2 prologue multiplies, 60 microcode
// steps through one shared multiplier and adder, done, hand over.
// The result is held until taken; a new word is accepted only after that.
// Reset clears state to zero and registers to their defaults.
// ----------------------------------------------------------------------------
module rk4_friction_spring_integrator_top #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               opcode,
	input  wire logic signed [31:0] load_position,
	input  wire logic signed [31:0] load_velocity,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      position_out,
	output logic signed [31:0]      velocity_out,
	output logic                    overflow_flag,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);
	import rk4_pkg::*;

	logic [30:0]        k_q, im_q, mu_q, h_q;
	logic signed [31:0] c_q;
	rk4_cmd_t           cmd;
	rk4_sts_t           sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q  <= 31'd65536;
			c_q  <= '0;
			im_q <= 31'd65536;
			mu_q <= '0;
			h_q  <= 31'd655;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_K:    k_q  <= cfg_data[30:0];
				REG_C:    c_q  <= cfg_data;
				REG_INVM: im_q <= cfg_data[30:0];
				REG_MU:   mu_q <= cfg_data[30:0];
				REG_H:    h_q  <= cfg_data[30:0];
				default:  ;
			endcase
		end
	end

	rk4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	rk4_dp #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.sts                  (sts),
		.load_position        (load_position),
		.load_velocity        (load_velocity),
		.spring_stiffness     (k_q),
		.hardening_factor     (c_q),
		.inverse_mass         (im_q),
		.friction_coefficient (mu_q),
		.time_step            (h_q),
		.position_out         (position_out),
		.velocity_out         (velocity_out),
		.overflow_flag        (overflow_flag)
	);

endmodule
`default_nettype wire

### rtl/rk4_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rk4_ctrl
// Handshake controller: accepts a word, starts the datapath, holds result.
// ----------------------------------------------------------------------------
module rk4_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic            opcode,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output rk4_pkg::rk4_cmd_t    cmd,
	input  wire rk4_pkg::rk4_sts_t sts
);
	import rk4_pkg::*;

	rk4_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_RUN;
			ST_RUN:  state_d = sts.done ? ST_OUT : ST_WAIT;
			ST_WAIT: if (sts.done) state_d = ST_OUT;
			ST_OUT:  if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		out_valid = (state_q == ST_OUT);
		cmd.start_load = (state_q == ST_IDLE) && in_valid && (opcode == OP_LOAD);
		cmd.start_step = (state_q == ST_IDLE) && in_valid && (opcode == OP_STEP);
	end

endmodule
`default_nettype wire

### rtl/rk4_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rk4_dp
// Shared-multiplier datapath with microcode sequencer for RK4 stages.
// ----------------------------------------------------------------------------
module rk4_dp #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rk4_pkg::rk4_cmd_t   cmd,
	output rk4_pkg::rk4_sts_t        sts,
	input  wire logic signed [31:0]  load_position,
	input  wire logic signed [31:0]  load_velocity,
	input  wire logic [30:0]         spring_stiffness,
	input  wire logic signed [31:0]  hardening_factor,
	input  wire logic [30:0]         inverse_mass,
	input  wire logic [30:0]         friction_coefficient,
	input  wire logic [30:0]         time_step,
	output logic signed [31:0]       position_out,
	output logic signed [31:0]       velocity_out,
	output logic                     overflow_flag
);
	import rk4_pkg::*;

	localparam int W = DATA_WIDTH;
	localparam int PW = 2 * W + 2;
	localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
	localparam longint G_FIX = ((64'd981 << FRAC_BITS) + 64'd50) / 64'd100;
	// reciprocal of three, ceil(2^(W+1)/3)
	localparam logic [W+1:0] DIV3_N = (W+2)'(1) << (W+1);
	localparam logic [W:0]   DIV3_M = (W+1)'((DIV3_N + (W+2)'(2)) / (W+2)'(3));

	// register file
	typedef enum logic [4:0] {
		R_X, R_V, R_XS, R_VS, R_K1X, R_K1V, R_K2X, R_K2V, R_K3X, R_K3V,
		R_K4X, R_K4V, R_T0, R_T1, R_ACC, R_SX, R_SV, R_CK, R_FR, R_K, R_H,
		R_IM, R_ZERO
	} reg_t;
	localparam int NREG = 23;

	typedef enum logic [2:0] {
		OP_MUL, OP_MULH, OP_ADD, OP_SUB, OP_DIV6ADD, OP_FRIC, OP_NOP
	} uop_t;

	typedef struct packed {
		uop_t op;
		reg_t a;
		reg_t b;
		reg_t d;
	} uins_t;

	logic signed [W-1:0] rf_q [NREG];
	logic [STEP_W-1:0]   pc_q;
	logic                busy_q;
	logic                ovf_q;
	logic                done_q;
	logic signed [W-1:0] sa, sb, res;
	logic                rovf;
	uins_t               ui;

	function automatic uins_t mk(input uop_t o, input reg_t a, input reg_t b,
			input reg_t d);
		uins_t u;
		u.op = o; u.a = a; u.b = b; u.d = d;
		return u;
	endfunction

	// RK4 microcode; each accel(x=XS, v=VS) into dst uses T0,T1
	function automatic uins_t prog(input logic [STEP_W-1:0] p);
		uins_t u;
		u = mk(OP_NOP, R_ZERO, R_ZERO, R_ZERO);
		unique case (p)
			6'd0:  u = mk(OP_ADD, R_X, R_ZERO, R_XS);
			6'd1:  u = mk(OP_ADD, R_V, R_ZERO, R_VS);
			6'd2:  u = mk(OP_ADD, R_VS, R_ZERO, R_K1X);
			6'd3:  u = mk(OP_MUL, R_XS, R_XS, R_T0);
			6'd4:  u = mk(OP_MUL, R_CK, R_T0, R_T0);
			6'd5:  u = mk(OP_ADD, R_K, R_T0, R_T0);
			6'd6:  u = mk(OP_MUL, R_T0, R_XS, R_T0);
			6'd7:  u = mk(OP_MUL, R_T0, R_IM, R_T0);
			6'd8:  u = mk(OP_SUB, R_ZERO, R_T0, R_T0);
			6'd9:  u = mk(OP_FRIC, R_T0, R_FR, R_K1V);
			6'd10: u = mk(OP_MULH, R_H, R_K1X, R_T1);
			6'd11: u = mk(OP_ADD, R_X, R_T1, R_XS);
			6'd12: u = mk(OP_MULH, R_H, R_K1V, R_T1);
			6'd13: u = mk(OP_ADD, R_V, R_T1, R_VS);
			6'd14: u = mk(OP_ADD, R_VS, R_ZERO, R_K2X);
			6'd15: u = mk(OP_MUL, R_XS, R_XS, R_T0);
			6'd16: u = mk(OP_MUL, R_CK, R_T0, R_T0);
			6'd17: u = mk(OP_ADD, R_K, R_T0, R_T0);
			6'd18: u = mk(OP_MUL, R_T0, R_XS, R_T0);
			6'd19: u = mk(OP_MUL, R_T0, R_IM, R_T0);
			6'd20: u = mk(OP_SUB, R_ZERO, R_T0, R_T0);
			6'd21: u = mk(OP_FRIC, R_T0, R_FR, R_K2V);
			6'd22: u = mk(OP_MULH, R_H, R_K2X, R_T1);
			6'd23: u = mk(OP_ADD, R_X, R_T1, R_XS);
			6'd24: u = mk(OP_MULH, R_H, R_K2V, R_T1);
			6'd25: u = mk(OP_ADD, R_V, R_T1, R_VS);
			6'd26: u = mk(OP_ADD, R_VS, R_ZERO, R_K3X);
			6'd27: u = mk(OP_MUL, R_XS, R_XS, R_T0);
			6'd28: u = mk(OP_MUL, R_CK, R_T0, R_T0);
			6'd29: u = mk(OP_ADD, R_K, R_T0, R_T0);
			6'd30: u = mk(OP_MUL, R_T0, R_XS, R_T0);
			6'd31: u = mk(OP_MUL, R_T0, R_IM, R_T0);
			6'd32: u = mk(OP_SUB, R_ZERO, R_T0, R_T0);
			6'd33: u = mk(OP_FRIC, R_T0, R_FR, R_K3V);
			6'd34: u = mk(OP_MUL, R_H, R_K3X, R_T1);
			6'd35: u = mk(OP_ADD, R_X, R_T1, R_XS);
			6'd36: u = mk(OP_MUL, R_H, R_K3V, R_T1);
			6'd37: u = mk(OP_ADD, R_V, R_T1, R_VS);
			6'd38: u = mk(OP_ADD, R_VS, R_ZERO, R_K4X);
			6'd39: u = mk(OP_MUL, R_XS, R_XS, R_T0);
			6'd40: u = mk(OP_MUL, R_CK, R_T0, R_T0);
			6'd41: u = mk(OP_ADD, R_K, R_T0, R_T0);
			6'd42: u = mk(OP_MUL, R_T0, R_XS, R_T0);
			6'd43: u = mk(OP_MUL, R_T0, R_IM, R_T0);
			6'd44: u = mk(OP_SUB, R_ZERO, R_T0, R_T0);
			6'd45: u = mk(OP_FRIC, R_T0, R_FR, R_K4V);
			6'd46: u = mk(OP_ADD, R_K2X, R_K2X, R_T0);
			6'd47: u = mk(OP_ADD, R_K1X, R_T0, R_T0);
			6'd48: u = mk(OP_ADD, R_K3X, R_K3X, R_T1);
			6'd49: u = mk(OP_ADD, R_T0, R_T1, R_T0);
			6'd50: u = mk(OP_ADD, R_T0, R_K4X, R_SX);
			6'd51: u = mk(OP_ADD, R_K2V, R_K2V, R_T0);
			6'd52: u = mk(OP_ADD, R_K1V, R_T0, R_T0);
			6'd53: u = mk(OP_ADD, R_K3V, R_K3V, R_T1);
			6'd54: u = mk(OP_ADD, R_T0, R_T1, R_T0);
			6'd55: u = mk(OP_ADD, R_T0, R_K4V, R_SV);
			6'd56: u = mk(OP_MUL, R_H, R_SX, R_T0);
			6'd57: u = mk(OP_MUL, R_H, R_SV, R_T1);
			6'd58: u = mk(OP_DIV6ADD, R_X, R_T0, R_X);
			6'd59: u = mk(OP_DIV6ADD, R_V, R_T1, R_V);
			default: u = mk(OP_NOP, R_ZERO, R_ZERO, R_ZERO);
		endcase
		return u;
	endfunction

	localparam logic [STEP_W-1:0] LAST = 6'd59;

	// magnitude product with rounding and saturation; one multiply per cycle
	logic [W-1:0]        ma, mb;
	logic [2*W-1:0]      mp;
	logic [2*W:0]        mr;
	logic [2*W:0]        msh;
	logic                mneg, movf;
	logic [W:0]          mlim;
	logic signed [W-1:0] mres;
	logic                sh1;
	logic signed [W:0]   sum;
	logic [W-1:0]        dmag;
	logic [W-1:0]        dnum;
	logic [2*W:0]        dprod;
	logic [W-1:0]        dq;
	logic signed [W-1:0] dval;
	logic                aovf;
	logic signed [W-1:0] fsel;

	assign ui  = prog(pc_q);
	assign sa  = rf_q[ui.a];
	assign sb  = rf_q[ui.b];
	assign sh1 = (ui.op == OP_MULH);

	always_comb begin
		mneg = sa[W-1] ^ sb[W-1];
		ma = sa[W-1] ? W'(-sa) : sa;
		mb = sb[W-1] ? W'(-sb) : sb;
		mp = ma * mb;
		if (sh1) begin
			mr  = {1'b0, mp} + ((2*W+1)'(1) << FRAC_BITS);
			msh = mr >> (FRAC_BITS + 1);
		end else begin
			mr  = {1'b0, mp} + ((2*W+1)'(1) << (FRAC_BITS - 1));
			msh = mr >> FRAC_BITS;
		end
		mlim = mneg ? {2'b01, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b0}}, 1'b0} | (W+1)'(VMAX);
		movf = (msh > (2*W+1)'(mlim));
		if (movf) begin
			mres = mneg ? VMIN : VMAX;
		end else begin
			mres = mneg ? W'(-msh[W-1:0]) : msh[W-1:0];
		end
	end

	// div6 of sb (signed) then add to sa; n/6 = (n/2)/3 by reciprocal multiply; friction sign select
	always_comb begin
		dmag  = sb[W-1] ? W'(-sb) : sb;
		dnum  = (dmag + W'(3)) >> 1;
		dprod = (2*W+1)'(dnum) * (2*W+1)'(DIV3_M);
		dq    = dprod[2*W:W+1];
		dval  = sb[W-1] ? W'(-dq) : dq;
		fsel  = rf_q[R_VS] > 0 ? W'(-sb) : sb;
	end

	always_comb begin
		res  = '0;
		aovf = 1'b0;
		sum  = '0;
		unique case (ui.op)
			OP_MUL, OP_MULH: begin
				res = mres;
				aovf = movf;
			end
			OP_ADD:     sum = {sa[W-1], sa} + {sb[W-1], sb};
			OP_SUB:     sum = {sa[W-1], sa} - {sb[W-1], sb};
			OP_DIV6ADD: sum = {sa[W-1], sa} + {dval[W-1], dval};
			OP_FRIC:    sum = {sa[W-1], sa} + {fsel[W-1], fsel};
			default:    sum = '0;
		endcase
		if (ui.op != OP_MUL && ui.op != OP_MULH) begin
			if (sum[W] != sum[W-1]) begin
				aovf = (ui.op != OP_NOP);
				res = sum[W] ? VMIN : VMAX;
			end else begin
				res = sum[W-1:0];
			end
		end
		rovf = aovf;
	end

	// config registers clamped into data range
	function automatic logic signed [W-1:0] cfgu(input logic [30:0] v);
		if (W < 32 && 64'(v) > 64'(VMAX)) return VMAX;
		return W'(v);
	endfunction
	function automatic logic signed [W-1:0] cfgs(input logic signed [31:0] v);
		if (W < 32 && 64'(signed'(v)) > 64'(signed'(VMAX))) return VMAX;
		if (W < 32 && 64'(signed'(v)) < 64'(signed'(VMIN))) return VMIN;
		return W'(v);
	endfunction

	logic signed [W-1:0] lx, lv;
	logic                lxo, lvo;
	always_comb begin
		lx = cfgs(load_position);
		lv = cfgs(load_velocity);
		lxo = (lx != W'(load_position)) || (W < 32 && 64'(signed'(lx)) !=
			64'(signed'(load_position)));
		lvo = (W < 32 && 64'(signed'(lv)) != 64'(signed'(load_velocity)));
	end

	function automatic logic signed [W-1:0] pmul(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b, output logic o);
		logic n;
		logic [W-1:0] ua, ub;
		logic [2*W:0] r;
		logic [W:0] lim;
		n = a[W-1] ^ b[W-1];
		ua = a[W-1] ? W'(-a) : a;
		ub = b[W-1] ? W'(-b) : b;
		r = ({1'b0, (2*W)'(ua) * (2*W)'(ub)} + ((2*W+1)'(1) << (FRAC_BITS - 1)))
			>> FRAC_BITS;
		lim = n ? {2'b01, {(W-1){1'b0}}} : (W+1)'(VMAX);
		o = (r > (2*W+1)'(lim));
		if (o) return n ? VMIN : VMAX;
		return n ? W'(-r[W-1:0]) : r[W-1:0];
	endfunction

	// pre-step: CK=c*k, FR=mu*g computed by the pmul multipliers in prologue
	logic [1:0] pre_q;
	logic signed [W-1:0] pa, pb;
	logic pf0, pf1;

	// prologue multiplies: c*k and mu*g
	always_comb begin
		pa = pmul(rf_q[R_CK], rf_q[R_K], pf0);
		pb = pmul(rf_q[R_FR], W'(G_FIX > 64'(VMAX) ? 64'(VMAX) : G_FIX), pf1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
			ovf_q  <= 1'b0;
			done_q <= 1'b0;
			pre_q  <= '0;
			for (int i = 0; i < NREG; i++) rf_q[i] <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start_load) begin
				rf_q[R_X] <= lx;
				rf_q[R_V] <= lv;
				ovf_q <= lxo || lvo;
				done_q <= 1'b1;
			end else if (cmd.start_step) begin
				rf_q[R_K]  <= cfgu(spring_stiffness);
				rf_q[R_H]  <= cfgu(time_step);
				rf_q[R_IM] <= cfgu(inverse_mass);
				rf_q[R_CK] <= cfgs(hardening_factor);
				rf_q[R_FR] <= cfgu(friction_coefficient);
				rf_q[R_ZERO] <= '0;
				ovf_q <= 1'b0;
				pre_q <= 2'd1;
				pc_q <= '0;
			end else if (pre_q == 2'd1) begin
				rf_q[R_CK] <= pa;
				ovf_q <= ovf_q | pf0;
				pre_q <= 2'd2;
			end else if (pre_q == 2'd2) begin
				rf_q[R_FR] <= pb;
				ovf_q <= ovf_q | pf1;
				pre_q <= 2'd0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (ui.op != OP_NOP) rf_q[ui.d] <= res;
				ovf_q <= ovf_q | rovf;
				if (pc_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					pc_q <= pc_q + 1'b1;
				end
			end
		end
	end

	function automatic logic signed [31:0] o32(input logic signed [W-1:0] v);
		if (W > 32 && 64'(signed'(v)) > 64'sd2147483647) return 32'h7fffffff;
		if (W > 32 && 64'(signed'(v)) < -64'sd2147483648) return 32'h80000000;
		return 32'(v);
	endfunction

	assign sts.done      = done_q;
	assign position_out  = o32(rf_q[R_X]);
	assign velocity_out  = o32(rf_q[R_V]);
	assign overflow_flag = ovf_q;

endmodule
`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the friction spring RK4 integrator. A local
// predictor tracks position, velocity and register settings in signed
// Q16.16 and forms the expected word for every accepted input. Directed
// loads and steps, register extremes, backpressure and random runs are
// covered with random gaps on both handshakes.
// ----------------------------------------------------------------------------
module tb_top;
	import rk4_pkg::*;

	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;
	localparam longint GRAV   = 64'sd642908;
	localparam int     FB     = 16;
	localparam int     CYCLE_LIMIT = 3000000;

	typedef struct {
		logic signed [31:0] pos;
		logic signed [31:0] vel;
		logic               flag;
	} state_word_t;

	logic clk, arst_n;
	logic in_valid, in_ready, opcode;
	logic signed [31:0] load_position, load_velocity;
	logic out_valid, out_ready, overflow_flag;
	logic signed [31:0] position_out, velocity_out;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	rk4_friction_spring_integrator_top DUT (.*);

	// predictor state
	longint mdl_k, mdl_c, mdl_invm, mdl_mu, mdl_h, mdl_x, mdl_v;
	logic   sat_seen;
	state_word_t pending_q[$];
	int     mismatches;
	int     hold_cycles;
	bit     no_idle;
	longint cycles;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic longint clip(longint a);
		if (a > SAT_HI) begin sat_seen = 1; return SAT_HI; end
		if (a < SAT_LO) begin sat_seen = 1; return SAT_LO; end
		return a;
	endfunction

	function automatic longint add_sat(longint a, longint b);
		return clip(a + b);
	endfunction

	function automatic longint sub_sat(longint a, longint b);
		return clip(a - b);
	endfunction

	function automatic longint mul_rnd(longint a, longint b, int sh);
		logic [127:0] p;
		logic neg;
		longint unsigned ua, ub, lim;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		p = {64'd0, ua} * {64'd0, ub};
		p = (p + (128'd1 << (sh - 1))) >> sh;
		lim = neg ? SAT_HI + 1 : SAT_HI;
		if (p > lim) begin
			sat_seen = 1;
			return neg ? SAT_LO : SAT_HI;
		end
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic longint div_six(longint a);
		longint unsigned m;
		m = (a < 0) ? -a : a;
		m = (m + 3) / 6;
		return (a < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint accel(longint x, longint v);
		longint ck, stiff, acc, fr;
		ck = mul_rnd(mdl_c, mdl_k, FB);
		stiff = add_sat(mdl_k, mul_rnd(ck, mul_rnd(x, x, FB), FB));
		acc = sub_sat(0, mul_rnd(mul_rnd(stiff, x, FB), mdl_invm, FB));
		fr = mul_rnd(mdl_mu, GRAV, FB);
		return (v > 0) ? sub_sat(acc, fr) : add_sat(acc, fr);
	endfunction

	function automatic state_word_t rk4_advance(logic op, logic signed [31:0] lp,
		logic signed [31:0] lv);
		longint x, v, a1, a2, a3, a4, x2, v2, x3, v3, x4, v4, sx, sv;
		state_word_t w;
		sat_seen = 0;
		if (op == OP_LOAD) begin
			mdl_x = lp;
			mdl_v = lv;
		end else begin
			x = mdl_x;
			v = mdl_v;
			a1 = accel(x, v);
			x2 = add_sat(x, mul_rnd(mdl_h, v, FB + 1));
			v2 = add_sat(v, mul_rnd(mdl_h, a1, FB + 1));
			a2 = accel(x2, v2);
			x3 = add_sat(x, mul_rnd(mdl_h, v2, FB + 1));
			v3 = add_sat(v, mul_rnd(mdl_h, a2, FB + 1));
			a3 = accel(x3, v3);
			x4 = add_sat(x, mul_rnd(mdl_h, v3, FB));
			v4 = add_sat(v, mul_rnd(mdl_h, a3, FB));
			a4 = accel(x4, v4);
			sx = add_sat(add_sat(add_sat(v, add_sat(v2, v2)), add_sat(v3, v3)), v4);
			sv = add_sat(add_sat(add_sat(a1, add_sat(a2, a2)), add_sat(a3, a3)), a4);
			mdl_x = add_sat(x, div_six(mul_rnd(mdl_h, sx, FB)));
			mdl_v = add_sat(v, div_six(mul_rnd(mdl_h, sv, FB)));
		end
		w.pos = mdl_x[31:0];
		w.vel = mdl_v[31:0];
		w.flag = sat_seen;
		return w;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			default: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
		endcase
	endfunction

	task automatic send_word(logic op, logic [31:0] lp, logic [31:0] lv);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		opcode <= op;
		load_position <= lp;
		load_velocity <= lv;
		do @(posedge clk); while (!in_ready);
		pending_q.push_back(rk4_advance(op, lp, lv));
	endtask

	task automatic send_random();
		send_word($urandom_range(0, 99) < 85 ? OP_STEP : OP_LOAD, pick_value(), pick_value());
	endtask

	task automatic drain();
		@(negedge clk) in_valid <= 1'b0;
		wait (pending_q.size() == 0);
		repeat (80) @(posedge clk);
	endtask

	task automatic cfg_write(rk4_reg_t idx, logic [31:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk) cfg_we <= 1'b0;
		case (idx)
			REG_K:    mdl_k = data[30:0];
			REG_C:    mdl_c = longint'($signed(data));
			REG_INVM: mdl_invm = data[30:0];
			REG_MU:   mdl_mu = data[30:0];
			REG_H:    mdl_h = data[30:0];
			default: ;
		endcase
	endtask

	task automatic cfg_all(logic [31:0] k, logic [31:0] c, logic [31:0] im,
		logic [31:0] mu, logic [31:0] h);
		drain();
		cfg_write(REG_K, k);
		cfg_write(REG_C, c);
		cfg_write(REG_INVM, im);
		cfg_write(REG_MU, mu);
		cfg_write(REG_H, h);
	endtask

	task automatic test_directed();
		send_word(OP_STEP, 0, 0);
		send_word(OP_LOAD, 32'h7fffffff, 32'h80000000);
		send_word(OP_STEP, 0, 0);
		send_word(OP_LOAD, 32'h80000000, 32'h7fffffff);
		send_word(OP_STEP, 32'hffffffff, 32'hffffffff);
		send_word(OP_LOAD, 32'h00010000, 0);
		send_word(OP_STEP, 0, 0);
		send_word(OP_STEP, 0, 0);
		cfg_all(32'h00010000, 32'h00008000, 32'h00008000, 32'h00004000, 32'h00000800);
		send_word(OP_LOAD, 0, 0);
		send_word(OP_STEP, 0, 0);
		send_word(OP_LOAD, 0, 32'h00010000);
		send_word(OP_STEP, 0, 0);
		send_word(OP_LOAD, 32'hffff0000, 32'hfffe0000);
		send_word(OP_STEP, 0, 0);
		send_word(OP_STEP, 0, 0);
		cfg_all(0, 0, 1, 0, 1);
		send_word(OP_LOAD, 32'h00050000, 32'h00030000);
		send_word(OP_STEP, 0, 0);
	endtask

	task automatic test_register_extremes();
		logic [31:0] lo_hi[2];
		lo_hi = '{32'h7fffffff, 32'h00000001};
		cfg_all(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		repeat (6) send_random();
		cfg_all(32'h7fffffff, 32'h7fffffff, 1, 0, 32'h00010000);
		repeat (6) send_random();
		cfg_all(0, 32'h80000000, lo_hi[0], 32'h7fffffff, 1);
		repeat (6) send_random();
	endtask

	task automatic test_backpressure();
		cfg_all(32'h00020000, 32'h00001000, 32'h00010000, 32'h00000800, 32'h00000400);
		hold_cycles = 500;
		repeat (12) send_random();
		drain();
		repeat (10) send_random();
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 8; ph++) begin
			cfg_all($urandom_range(0, 1 << 19), $signed($urandom_range(0, 1 << 17)) - (1 << 16),
				$urandom_range(1, 1 << 18), $urandom_range(0, 1 << 15),
				$urandom_range(1, 1 << 13));
			no_idle = (ph == 3);
			send_word(OP_LOAD, pick_value(), pick_value());
			repeat (170) send_random();
		end
		no_idle = 0;
	endtask

	// result sink
	initial begin
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= 1'b0;
			end else if (no_idle) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) < 70);
				if ($urandom_range(0, 99) == 0) hold_cycles = $urandom_range(10, 60);
			end
		end
	end

	// checker
	initial begin
		state_word_t w;
		mismatches = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected word: pos %h vel %h flag %b",
						position_out, velocity_out, overflow_flag);
				end else begin
					w = pending_q.pop_front();
					if (w.pos !== position_out || w.vel !== velocity_out ||
						w.flag !== overflow_flag) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp pos %h vel %h flag %b, got pos %h vel %h flag %b",
								w.pos, w.vel, w.flag, position_out, velocity_out, overflow_flag);
					end
				end
			end
		end
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 0;
		in_valid = 0;
		opcode = 0;
		load_position = 0;
		load_velocity = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		hold_cycles = 0;
		no_idle = 0;
		mdl_k = 65536;
		mdl_c = 0;
		mdl_invm = 65536;
		mdl_mu = 0;
		mdl_h = 655;
		mdl_x = 0;
		mdl_v = 0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1;
		repeat (4) @(negedge clk);
		test_directed();
		test_register_extremes();
		test_backpressure();
		test_random();
		drain();
		if (mismatches == 0 && pending_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
